// ===== rtl/core/gregorian_date_difference_days_assert.svh =====
// Assertion macros used by the checker of the date difference block.
`ifndef GREGORIAN_DATE_DIFFERENCE_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_DIFFERENCE_DAYS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GDD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/gdd_pkg.sv =====
// Types, constants and calendar tables of the date difference block.
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int ORD_W   = 22;
    localparam int MLEN_W  = 5;
    localparam int MTERM_W = 9;
    localparam int B_W     = 10;

    // floor(y / 100) as (y * 5243) >> 19, exact for every year up to 9999
    localparam int DIV_MUL_W    = 13;
    localparam int DIV100_SHIFT = 19;
    localparam int MUL_W        = YEAR_W + DIV_MUL_W;
    localparam int Q_W          = MUL_W - DIV100_SHIFT;
    localparam logic [DIV_MUL_W-1:0] DIV100_MUL = 13'd5243;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MON_W-1:0]   MON_JAN   = 4'd1;
    localparam logic [MON_W-1:0]   MON_FEB   = 4'd2;
    localparam logic [MON_W-1:0]   MON_DEC   = 4'd12;
    localparam logic [MLEN_W-1:0]  FEB_LEAP  = 5'd29;
    localparam logic [ORD_W-1:0]   COUNT_MAX = 22'd3652059;

    typedef struct packed {
        logic                ok;
        logic [ORD_W-1:0]    ord;
    } date_ord_t;

    typedef struct packed {
        logic                base_ok;
        logic                feb;
        logic [DAY_W-1:0]    day;
        logic [MLEN_W-1:0]   mlen;
        logic [MTERM_W-1:0]  mterm;
        logic [YEAR_W-1:0]   year;
        logic [YEAR_W-1:0]   ya;
        logic [Q_W-1:0]      qy;
        logic [Q_W-1:0]      qya;
    } date_s1_t;

    typedef struct packed {
        logic                ok;
        logic [ORD_W-1:0]    a;
        logic [B_W-1:0]      b;
    } date_s2_t;

    function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [MLEN_W-1:0] r;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // Days before the month in a year that starts in March.
    function automatic logic [MTERM_W-1:0] month_term(input logic [MON_W-1:0] m);
        logic [MTERM_W-1:0] r;
        unique case (m)
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/gregorian_date_difference_days.sv =====
// Throughput: one beat per cycle while the output is not stalled; four register
// stages (two date ordinal pipelines in parallel, then compare and subtract into
// the output register). A stalled output holds its stage; bubbles ahead of it
// still fill. Reset clears the stage valid bits only; data registers are not
// reset.
module gregorian_date_difference_days (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [gdd_pkg::DAY_W-1:0]  start_day,
    input  logic [gdd_pkg::MON_W-1:0]  start_month,
    input  logic [gdd_pkg::YEAR_W-1:0] start_year,
    input  logic [gdd_pkg::DAY_W-1:0]  end_day,
    input  logic [gdd_pkg::MON_W-1:0]  end_month,
    input  logic [gdd_pkg::YEAR_W-1:0] end_year,
    input  logic                       include_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gdd_pkg::ORD_W-1:0]  day_count,
    output logic                       date_error
);
    import gdd_pkg::*;

    logic [3:0] valid_reg, valid_next;
    logic [3:0] en;
    logic [2:0] inc_reg;
    date_ord_t  start_ord, end_ord;

    logic [ORD_W-1:0] count_reg, count_next;
    logic             error_reg, error_next;
    logic [ORD_W-1:0] diff;

    // a stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        en[3] = !valid_reg[3] || out_ready;
        en[2] = !valid_reg[2] || en[3];
        en[1] = !valid_reg[1] || en[2];
        en[0] = !valid_reg[0] || en[1];
        valid_next[0] = en[0] ? in_valid     : valid_reg[0];
        valid_next[1] = en[1] ? valid_reg[0] : valid_reg[1];
        valid_next[2] = en[2] ? valid_reg[1] : valid_reg[2];
        valid_next[3] = en[3] ? valid_reg[2] : valid_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    gdd_date_ord u_start (
        .clk    (clk),
        .en     (en[2:0]),
        .day    (start_day),
        .month  (start_month),
        .year   (start_year),
        .result (start_ord)
    );

    gdd_date_ord u_end (
        .clk    (clk),
        .en     (en[2:0]),
        .day    (end_day),
        .month  (end_month),
        .year   (end_year),
        .result (end_ord)
    );

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            inc_reg[0] <= include_end;
        end
        if (en[1])
        begin
            inc_reg[1] <= inc_reg[0];
        end
        if (en[2])
        begin
            inc_reg[2] <= inc_reg[1];
        end
    end

    always_comb
    begin
        diff = end_ord.ord - start_ord.ord;
        if (!start_ord.ok || !end_ord.ok)
        begin
            count_next = '0;
            error_next = 1'b1;
        end
        else
        begin
            count_next = ((end_ord.ord > start_ord.ord) ? diff : '0) + ORD_W'(inc_reg[2]);
            error_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            count_reg <= count_next;
            error_reg <= error_next;
        end
    end

    assign in_ready   = en[0];
    assign out_valid  = valid_reg[3];
    assign day_count  = count_reg;
    assign date_error = error_reg;

endmodule

// ===== rtl/core/gdd_date_ord.sv =====
// Three-stage pipeline that checks one date and turns it into a day ordinal.
module gdd_date_ord (
    input  logic                       clk,
    input  logic [2:0]                 en,
    input  logic [gdd_pkg::DAY_W-1:0]  day,
    input  logic [gdd_pkg::MON_W-1:0]  month,
    input  logic [gdd_pkg::YEAR_W-1:0] year,
    output gdd_pkg::date_ord_t         result
);
    import gdd_pkg::*;

    date_s1_t  s1_next, s1_reg;
    date_s2_t  s2_next, s2_reg;
    date_ord_t s3_next, s3_reg;

    logic [MUL_W-1:0]  prod_y, prod_ya;
    logic [YEAR_W-1:0] ya;

    // stage 1: range checks, March-based year, reciprocal multiplies for /100
    always_comb
    begin
        ya              = (month <= MON_FEB) ? year - 1'b1 : year;
        prod_y          = MUL_W'(year) * MUL_W'(DIV100_MUL);
        prod_ya         = MUL_W'(ya) * MUL_W'(DIV100_MUL);
        s1_next.base_ok = (month >= MON_JAN) && (month <= MON_DEC) &&
                          (year != '0) && (year <= YEAR_MAX) && (day != '0);
        s1_next.feb     = (month == MON_FEB);
        s1_next.day     = day;
        s1_next.mlen    = month_len(month);
        s1_next.mterm   = month_term(month);
        s1_next.year    = year;
        s1_next.ya      = ya;
        s1_next.qy      = prod_y[DIV100_SHIFT +: Q_W];
        s1_next.qya     = prod_ya[DIV100_SHIFT +: Q_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_reg <= s1_next;
        end
    end

    logic [YEAR_W+1:0] hund;
    logic              is100;
    logic              leap;
    logic [MLEN_W-1:0] lim;

    // stage 2: leap rule, day limit, year part and month part of the ordinal
    always_comb
    begin
        hund       = (YEAR_W+2)'(s1_reg.qy) * (YEAR_W+2)'(100);
        is100      = (hund == (YEAR_W+2)'(s1_reg.year));
        leap       = ((s1_reg.year[1:0] == 2'b00) && !is100) ||
                     (is100 && (s1_reg.qy[1:0] == 2'b00));
        lim        = (s1_reg.feb && leap) ? FEB_LEAP : s1_reg.mlen;
        s2_next.ok = s1_reg.base_ok && (s1_reg.day <= lim);
        s2_next.a  = ORD_W'(s1_reg.ya) * ORD_W'(365) + ORD_W'(s1_reg.ya >> 2)
                     - ORD_W'(s1_reg.qya);
        s2_next.b  = B_W'(s1_reg.mterm) + B_W'(s1_reg.day) + B_W'(s1_reg.qya >> 2);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_reg <= s2_next;
        end
    end

    // stage 3: final sum
    always_comb
    begin
        s3_next.ok  = s2_reg.ok;
        s3_next.ord = s2_reg.a + ORD_W'(s2_reg.b);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_reg <= s3_next;
        end
    end

    assign result = s3_reg;

endmodule

// ===== rtl/core/gdd_checker.sv =====
// Port-level checker for the date difference block, with its bind.
`include "gregorian_date_difference_days_assert.svh"

module gdd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [gdd_pkg::ORD_W-1:0] day_count,
    input logic                      date_error
);
    import gdd_pkg::*;

    `GDD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `GDD_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && date_error, day_count == '0)
    `GDD_ASSERT_IMP(a_count_max, clk, rst_n, out_valid, day_count <= COUNT_MAX)
    // with the sink staying ready the accepted beat reaches the output
    `GDD_ASSERT_NXT(a_latency, clk, rst_n,
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind gregorian_date_difference_days gdd_checker u_gdd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .day_count  (day_count),
    .date_error (date_error)
);
